// ----- hw/rtl/msa_pkg.sv -----
// Package: shared types, constants and binary32 helper functions.
`default_nettype none
package msa_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 8'd1;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BYTE = 2'd2;

    localparam logic [31:0] QNAN = 32'h7fc00000;
    localparam logic [31:0] HALF_REBIAS = 32'h38000000;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic        last;
    } q_item_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        logic       found;
        n = '0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 6'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = '0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) found = 1'b1;
                else n = n + 5'd1;
            end
        end
        return n;
    endfunction

    // right shift keeping a sticky lsb
    function automatic logic [26:0] shr_sticky27(input logic [26:0] v, input logic [10:0] amt);
        logic [26:0] sh;
        logic        lost;
        sh = '0;
        lost = 1'b0;
        if (amt > 11'd26) begin
            sh = '0;
            lost = |v;
        end else begin
            sh = v >> amt[4:0];
            lost = |(v & ~(27'h7ffffff << amt[4:0]));
        end
        return {sh[26:1], sh[0] | lost};
    endfunction

    // sig: [26] hidden, [25:3] fraction, [2] guard, [1:0] sticky; exp biased
    function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] exp,
                                               input logic [26:0] sig);
        logic [26:0] sh;
        logic [7:0]  e8;
        logic        up;
        logic [30:0] mag;
        logic [10:0] amt;
        sh = sig;
        e8 = '0;
        amt = '0;
        if (exp >= 11'sd255) begin
            return {sign, 8'hff, 23'd0};
        end
        if (exp <= 11'sd0) begin
            amt = 11'd1 - $unsigned(exp);
            sh = shr_sticky27(sig, amt);
            e8 = 8'd0;
        end else begin
            e8 = exp[7:0];
        end
        up = sh[2] & (sh[3] | sh[1] | sh[0]);
        // carry runs into the exponent: subnormal to normal, max to inf
        mag = {e8, sh[25:3]} + {30'd0, up};
        return {sign, mag};
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mixed_format_scaled_accumulate_core.sv -----
// Top level: scaled accumulate y + a*x over fp32, fp16 or byte sources.
//
// Takes one word per cycle and returns one word per cycle while the output is
// not stalled. The accepting edge writes the four-entry queue behind the input
// port; from the queue head the word passes through the registers for multiply,
// normalize, round, align-add, normalize and the final rounding into the output
// register. The output register stalls the pipeline
// as a whole when it holds a word and m_axis_tready is low; the queue keeps
// taking input words until it is full. Product and sum are each rounded to
// nearest even; NaN results come out as 0x7fc00000. Write scale (index 0)
// and source format (index 1) only while no words are in flight.
`default_nettype none
module mixed_format_scaled_accumulate_core
    import msa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [63:0]            s_axis_tdata,  // x_value[31:0], y_value[63:32]
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // y_new[31:0]
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    q_item_t     q_item;
    q_item_t     q_head;
    logic [31:0] scale_bits;

    msa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item),
        .scale_bits    (scale_bits)
    );

    msa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    msa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .scale_bits    (scale_bits),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/msa_front.sv -----
// Front end: config registers, input acceptance and source conversion.
`default_nettype none
module msa_front
    import msa_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [63:0]            s_axis_tdata,  // x_value[31:0], y_value[63:32]
    input  wire logic                   s_axis_tlast,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   q_full,
    output logic                        q_push,
    output q_item_t                     q_item,
    output logic [31:0]                 scale_bits
);

    logic [31:0] scale_reg;
    logic [1:0]  format_reg;
    logic [31:0] x_raw;
    logic [31:0] x_conv;
    logic [31:0] half_mag;
    logic [7:0]  byte_val;
    logic [7:0]  byte_norm;
    logic [2:0]  byte_lz;

    assign cfg_ready = 1'b1;
    assign scale_bits = scale_reg;
    assign s_axis_tready = ~q_full;
    assign q_push = s_axis_tvalid & ~q_full;
    assign x_raw = s_axis_tdata[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
            format_reg <= FMT_FP32;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SCALE) scale_reg <= cfg_data;
            else if (cfg_index == REG_FORMAT) format_reg <= cfg_data[1:0];
        end
    end

    always_comb
    begin
        byte_val = x_raw[7:0];
        byte_lz = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (byte_val[i]) byte_lz = 3'(7 - i);
        end
        byte_norm = byte_val << byte_lz;
        half_mag = ({17'd0, x_raw[14:0]} << 13) + HALF_REBIAS;
        if (x_raw[14:10] == 5'd0) half_mag = '0;
        case (format_reg)
            FMT_FP16: x_conv = half_mag | {x_raw[15], 31'd0};
            FMT_BYTE:
            begin
                if (byte_val == 8'd0) x_conv = '0;
                else x_conv = {1'b0, 8'd134 - {5'd0, byte_lz}, byte_norm[6:0], 16'd0};
            end
            default: x_conv = x_raw;
        endcase
    end

    assign q_item = '{x_bits: x_conv, y_bits: s_axis_tdata[63:32], last: s_axis_tlast};

endmodule
`default_nettype wire

// ----- hw/rtl/msa_queue.sv -----
// Short queue between the front end and the arithmetic pipeline.
`default_nettype none
module msa_queue
    import msa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  q_item_t      push_item,
    output logic         full,
    input  wire logic    pop,
    output logic         empty,
    output q_item_t      head
);

    q_item_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg;
    logic [QPTR_W-1:0]  rptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop) rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/msa_back.sv -----
// Back end: pipelined binary32 multiply then add, with output register.
`default_nettype none
module msa_back
    import msa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] scale_bits,
    input  wire logic        q_empty,
    input  q_item_t          q_head,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // y_new[31:0]
    output logic             m_axis_tlast
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;

    // stage 1: product of significands
    logic [47:0]        prod_reg, prod_next;
    logic signed [10:0] e1_reg, e1_next;
    logic               ps1_reg, ps1_next;
    logic               pspec1_reg, pspec1_next;
    logic [31:0]        pbits1_reg, pbits1_next;
    logic [31:0]        y1_reg;
    logic               l1_reg;
    // stage 2: normalized product
    logic [26:0]        sig2_reg, sig2_next;
    logic signed [10:0] e2_reg, e2_next;
    logic               ps2_reg, pspec2_reg;
    logic [31:0]        pbits2_reg, y2_reg;
    logic               l2_reg;
    // stage 3: rounded product
    logic [31:0]        p3_reg, p3_next, y3_reg;
    logic               l3_reg;
    // stage 4: aligned sum
    logic [27:0]        sum4_reg, sum4_next;
    logic [7:0]         e4_reg, e4_next;
    logic               s4_reg, s4_next, zs4_reg, zs4_next;
    logic               spec4_reg, spec4_next;
    logic [31:0]        sbits4_reg, sbits4_next;
    logic               l4_reg;
    // stage 5: normalized sum
    logic [26:0]        sig5_reg, sig5_next;
    logic signed [10:0] e5_reg, e5_next;
    logic               s5_reg, zs5_reg, zero5_reg, zero5_next, spec5_reg;
    logic [31:0]        sbits5_reg;
    logic               l5_reg;
    // output
    logic [31:0]        out_reg, out_next;
    logic               lo_reg;

    assign adv = ~vo_reg | m_axis_tready;
    assign q_pop = adv & ~q_empty;
    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata = out_reg;
    assign m_axis_tlast = lo_reg;

    // stage 1
    always_comb
    begin
        logic [7:0]  ea, eb;
        logic [22:0] fa, fb;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        ea = scale_bits[30:23];
        fa = scale_bits[22:0];
        eb = q_head.x_bits[30:23];
        fb = q_head.x_bits[22:0];
        a_nan = (ea == 8'hff) && (fa != 23'd0);
        b_nan = (eb == 8'hff) && (fb != 23'd0);
        a_inf = (ea == 8'hff) && (fa == 23'd0);
        b_inf = (eb == 8'hff) && (fb == 23'd0);
        a_zero = (scale_bits[30:0] == 31'd0);
        b_zero = (q_head.x_bits[30:0] == 31'd0);
        ps1_next = scale_bits[31] ^ q_head.x_bits[31];
        prod_next = {24'd0, ea != 8'd0, fa} * {24'd0, eb != 8'd0, fb};
        e1_next = $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd126;
        pspec1_next = 1'b1;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) pbits1_next = QNAN;
        else if (a_inf || b_inf) pbits1_next = {ps1_next, 8'hff, 23'd0};
        else if (a_zero || b_zero) pbits1_next = {ps1_next, 31'd0};
        else
        begin
            pbits1_next = '0;
            pspec1_next = 1'b0;
        end
    end

    // stage 2
    always_comb
    begin
        logic [5:0]  lz;
        logic [47:0] pn;
        lz = lzc48(prod_reg);
        pn = prod_reg << lz;
        e2_next = e1_reg - $signed({5'd0, lz});
        sig2_next = {pn[47:22], |pn[21:0]};
    end

    // stage 3
    assign p3_next = pspec2_reg ? pbits2_reg : round_pack(ps2_reg, e2_reg, sig2_reg);

    // stage 4
    always_comb
    begin
        logic [7:0]  ey, ep, eb, es, d;
        logic        y_nan, p_nan, y_inf, p_inf, swap;
        logic [23:0] mb, ms;
        logic [26:0] ms_al;
        ey = y3_reg[30:23];
        ep = p3_reg[30:23];
        y_nan = (ey == 8'hff) && (y3_reg[22:0] != 23'd0);
        p_nan = (ep == 8'hff) && (p3_reg[22:0] != 23'd0);
        y_inf = (ey == 8'hff) && (y3_reg[22:0] == 23'd0);
        p_inf = (ep == 8'hff) && (p3_reg[22:0] == 23'd0);
        swap = (p3_reg[30:0] > y3_reg[30:0]);
        eb = swap ? ep : ey;
        es = swap ? ey : ep;
        mb = swap ? {ep != 8'd0, p3_reg[22:0]} : {ey != 8'd0, y3_reg[22:0]};
        ms = swap ? {ey != 8'd0, y3_reg[22:0]} : {ep != 8'd0, p3_reg[22:0]};
        eb = (eb == 8'd0) ? 8'd1 : eb;
        es = (es == 8'd0) ? 8'd1 : es;
        d = eb - es;
        ms_al = shr_sticky27({ms, 3'd0}, {3'd0, d});
        if (y3_reg[31] ^ p3_reg[31]) sum4_next = {1'b0, mb, 3'd0} - {1'b0, ms_al};
        else sum4_next = {1'b0, mb, 3'd0} + {1'b0, ms_al};
        e4_next = eb;
        s4_next = swap ? p3_reg[31] : y3_reg[31];
        zs4_next = y3_reg[31] & p3_reg[31];
        spec4_next = 1'b1;
        if (y_nan || p_nan || (y_inf && p_inf && (y3_reg[31] != p3_reg[31]))) sbits4_next = QNAN;
        else if (y_inf) sbits4_next = {y3_reg[31], 8'hff, 23'd0};
        else if (p_inf) sbits4_next = {p3_reg[31], 8'hff, 23'd0};
        else
        begin
            sbits4_next = '0;
            spec4_next = 1'b0;
        end
    end

    // stage 5
    always_comb
    begin
        logic [4:0] lz;
        lz = lzc27(sum4_reg[26:0]);
        zero5_next = (sum4_reg == 28'd0);
        if (sum4_reg[27])
        begin
            sig5_next = {sum4_reg[27:2], sum4_reg[1] | sum4_reg[0]};
            e5_next = $signed({3'd0, e4_reg}) + 11'sd1;
        end
        else
        begin
            sig5_next = sum4_reg[26:0] << lz;
            e5_next = $signed({3'd0, e4_reg}) - $signed({6'd0, lz});
        end
    end

    // output
    always_comb
    begin
        if (spec5_reg) out_next = sbits5_reg;
        else if (zero5_reg) out_next = {zs5_reg, 31'd0};
        else out_next = round_pack(s5_reg, e5_reg, sig5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= ~q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            vo_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            e1_reg <= e1_next;
            ps1_reg <= ps1_next;
            pspec1_reg <= pspec1_next;
            pbits1_reg <= pbits1_next;
            y1_reg <= q_head.y_bits;
            l1_reg <= q_head.last;

            sig2_reg <= sig2_next;
            e2_reg <= e2_next;
            ps2_reg <= ps1_reg;
            pspec2_reg <= pspec1_reg;
            pbits2_reg <= pbits1_reg;
            y2_reg <= y1_reg;
            l2_reg <= l1_reg;

            p3_reg <= p3_next;
            y3_reg <= y2_reg;
            l3_reg <= l2_reg;

            sum4_reg <= sum4_next;
            e4_reg <= e4_next;
            s4_reg <= s4_next;
            zs4_reg <= zs4_next;
            spec4_reg <= spec4_next;
            sbits4_reg <= sbits4_next;
            l4_reg <= l3_reg;

            sig5_reg <= sig5_next;
            e5_reg <= e5_next;
            s5_reg <= s4_reg;
            zs5_reg <= zs4_reg;
            zero5_reg <= zero5_next;
            spec5_reg <= spec4_reg;
            sbits5_reg <= sbits4_reg;
            l5_reg <= l4_reg;

            out_reg <= out_next;
            lo_reg <= l5_reg;
        end
    end

endmodule
`default_nettype wire

// ----- bench/mixed_format_scaled_accumulate_core_tb.sv -----
// Self-checking bench for the mixed-format scaled accumulate core.
`timescale 1ns / 1ps
module mixed_format_scaled_accumulate_core_tb;
    import msa_pkg::*;

    class saxpy_scoreboard;
        bit [31:0] scale;
        bit [1:0]  fmt;
        bit [32:0] sums_due[$];
        int        errors;

        static function bit [31:0] round_f32(bit s, bit [127:0] m, int e);
            int        p;
            int        be;
            int        sh;
            bit [127:0] q;
            bit        rnd;
            bit        st;
            longint    t;
            p = 127;
            while (!m[p]) p--;
            be = p + e + 127;
            sh = (be >= 1) ? p - 23 : -149 - e;
            if (sh > 0) begin
                if (sh > 127) begin
                    q = '0;
                    rnd = 1'b0;
                    st = 1'b1;
                end else begin
                    q = m >> sh;
                    rnd = m[sh-1];
                    st = (m & ((128'b1 << (sh - 1)) - 1)) != 0;
                end
                if (rnd && (st || q[0])) q = q + 1;
            end else begin
                q = m << (-sh);
            end
            // rounding carry moves into the exponent by itself
            t = (be >= 1) ? (longint'(be - 1) << 23) + longint'(q[31:0]) : longint'(q[31:0]);
            if (t >= (longint'(255) << 23)) return {s, 8'hff, 23'd0};
            return {s, t[30:0]};
        endfunction

        static function bit is_nan(bit [31:0] v);
            return v[30:23] == 8'hff && v[22:0] != 0;
        endfunction

        static function bit is_inf(bit [31:0] v);
            return v[30:23] == 8'hff && v[22:0] == 0;
        endfunction

        static function void split(bit [31:0] v, output bit [127:0] m, output int e);
            if (v[30:23] == 0) begin
                m = v[22:0];
                e = -149;
            end else begin
                m = {1'b1, v[22:0]};
                e = int'(v[30:23]) - 150;
            end
        endfunction

        static function bit [31:0] f32_mul(bit [31:0] a, bit [31:0] b);
            bit [127:0] ma;
            bit [127:0] mb;
            int ea;
            int eb;
            bit s;
            s = a[31] ^ b[31];
            if (is_nan(a) || is_nan(b)) return QNAN;
            if (is_inf(a) || is_inf(b)) begin
                if (a[30:0] == 0 || b[30:0] == 0) return QNAN;
                return {s, 8'hff, 23'd0};
            end
            if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
            split(a, ma, ea);
            split(b, mb, eb);
            return round_f32(s, ma * mb, ea + eb);
        endfunction

        static function bit [31:0] f32_add(bit [31:0] a, bit [31:0] b);
            bit [127:0] ma;
            bit [127:0] mb;
            bit [127:0] m;
            bit [31:0]  t;
            int ea;
            int eb;
            int d;
            int e;
            bit s;
            if (is_nan(a) || is_nan(b)) return QNAN;
            if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN;
            if (is_inf(a)) return a;
            if (is_inf(b)) return b;
            if (b[30:23] > a[30:23]) begin
                t = a;
                a = b;
                b = t;
            end
            split(a, ma, ea);
            split(b, mb, eb);
            d = ea - eb;
            if (d > 100) begin
                // far-off operand only acts as a sticky bit
                ma = ma << 100;
                mb = (mb != 0);
                e = ea - 100;
            end else begin
                ma = ma << d;
                e = eb;
            end
            if (a[31] == b[31]) begin
                m = ma + mb;
                s = a[31];
            end else if (ma >= mb) begin
                m = ma - mb;
                s = a[31];
            end else begin
                m = mb - ma;
                s = b[31];
            end
            if (m == 0) return {a[31] & b[31], 31'd0};
            return round_f32(s, m, e);
        endfunction

        function bit [31:0] widen_x(bit [31:0] raw);
            bit [31:0] mag;
            case (fmt)
                FMT_FP16:
                begin
                    mag = ({17'd0, raw[14:0]} << 13) + HALF_REBIAS;
                    if (raw[14:10] == 0) mag = '0;
                    return mag | ({16'd0, raw[15], 15'd0} << 16);
                end
                FMT_BYTE:
                begin
                    if (raw[7:0] == 0) return '0;
                    return round_f32(1'b0, raw[7:0], 0);
                end
                default: return raw;
            endcase
        endfunction

        function void note_input(bit [31:0] x, bit [31:0] y, bit last);
            sums_due.push_back({last, f32_add(y, f32_mul(widen_x(x), scale))});
        endfunction

        function void check_result(bit [31:0] data, bit last);
            bit [32:0] want;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected word, actual %h last %b", $time, data, last);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (want[31:0] !== data) begin
                $display("%0t: y_new expected %h actual %h", $time, want[31:0], data);
                errors++;
            end
            if (want[32] !== last) begin
                $display("%0t: last expected %b actual %b", $time, want[32], last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [63:0]            s_axis_tdata;  // x_value[31:0], y_value[63:32]
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [31:0]            m_axis_tdata;  // y_new[31:0]
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    saxpy_scoreboard sb;
    int ready_pct;
    int gap_max;
    int idle_cycles;

    mixed_format_scaled_accumulate_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver: checks each word, stalls on a per-phase duty
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // watchdog on handshake activity
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 20000)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_SCALE) sb.scale = val;
        else if (idx == REG_FORMAT) sb.fmt = val[1:0];
    endtask

    task automatic send_word(input logic [31:0] x, input logic [31:0] y, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(x, y, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.sums_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_f32();
        logic [31:0] specials[6] = '{32'h0, 32'h80000000, 32'h7f800000, 32'hff800000,
                                     32'h7fc00001, 32'h7f7fffff};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            8: return specials[$urandom_range(0, 5)];
            9: return {1'($urandom), 8'h00, 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_x(input logic [1:0] f);
        logic [31:0] r;
        r = $urandom;
        if (f == FMT_FP16 && $urandom_range(0, 3) == 0)
            r[14:10] = ($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0;
        else if (f != FMT_FP16 && f != FMT_BYTE)
            r = rand_f32();
        return r;
    endfunction

    logic [31:0] scales[12] = '{32'h3f800000, 32'h0, 32'hc0000000, 32'h7f7fffff,
                                32'h00000001, 32'h7f800000, 32'h7fc00001, 32'h3e9a0000,
                                32'h80000000, 32'hffffffff, 32'h1a2b3c4d, 32'h5f000000};
    logic [31:0] fmts[12]   = '{32'd1, 32'd2, 32'd0, 32'd1, 32'd2, 32'd0,
                                32'd3, 32'hfffffffe, 32'd1, 32'd0, 32'hfffffffd, 32'd2};
    logic [31:0] picks_x[8] = '{32'h0000_7c00, 32'hffff_fc01, 32'h0000_03ff, 32'h0000_8000,
                                32'h0000_00ff, 32'hffff_ff00, 32'h7f7f_ffff, 32'h8000_0001};
    logic [31:0] picks_y[8] = '{32'h0, 32'h80000000, 32'h7f800000, 32'hff7fffff,
                                32'h00000001, 32'hffffffff, 32'h7f7fffff, 32'h3f800000};

    initial
    begin
        int burst;
        sb = new();
        ready_pct     = 100;
        gap_max       = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_SCALE, scales[ph]);
            write_reg(REG_FORMAT, fmts[ph]);
            // out-of-range index must leave both registers alone
            write_reg(CFG_INDEX_W'($urandom_range(2, 255)), $urandom);
            cfg_valid <= 1'b0;
            ready_pct = (ph % 4 == 0) ? 100 : $urandom_range(20, 95);
            gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(1, 10);
            if (ph < 3)
                for (int i = 0; i < 8; i++)
                    send_word(picks_x[i], picks_y[i], i[0]);
            burst = $urandom_range(1, 20);
            for (int i = 0; i < 145; i++)
            begin
                send_word(rand_x(fmts[ph][1:0]), rand_f32(), 1'($urandom));
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 20);
                    if (gap_max != 0)
                    begin
                        s_axis_tvalid <= 1'b0;
                        repeat ($urandom_range(1, gap_max)) @(posedge clk);
                    end
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
